// ===== sv/sdbc_pkg.sv =====
// Shared constants for the sample DMA buffer cache.
package sdbc_pkg;

  // Default pool size
  localparam int NUM_BUFFERS_DEF = 16;

  // Reset value of the buffer size register, in bytes
  localparam logic [15:0] BUFFER_BYTES_RST = 16'h0800;

  // Frames an entry may stay unused before a tick frees it
  localparam logic [31:0] AGE_LAG = 32'd2;

  // Field widths
  localparam int ADDR_W = 31;
  localparam int LEN_W  = 16;
  localparam int IDX_W  = 4;
  localparam int TIME_W = 32;

  // Input function codes
  localparam logic FUNC_REQ  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

endpackage

// ===== sv/sdbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sdbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sdbc_links.sv =====
// Next/prev link tables of the buffer lists, one read and one write port each.
module sdbc_links #(
  parameter int NUM_BUFFERS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [$clog2(NUM_BUFFERS)-1:0] nx_ra,
  output logic [$clog2(NUM_BUFFERS+1)-1:0] nx_rd,
  input  logic [$clog2(NUM_BUFFERS)-1:0] pv_ra,
  output logic [$clog2(NUM_BUFFERS+1)-1:0] pv_rd,
  input  logic                           nx_we,
  input  logic [$clog2(NUM_BUFFERS)-1:0] nx_wa,
  input  logic [$clog2(NUM_BUFFERS+1)-1:0] nx_wd,
  input  logic                           pv_we,
  input  logic [$clog2(NUM_BUFFERS)-1:0] pv_wa,
  input  logic [$clog2(NUM_BUFFERS+1)-1:0] pv_wd
);

  localparam int LW = $clog2(NUM_BUFFERS + 1);

  logic [LW-1:0] nxt_tab [NUM_BUFFERS];
  logic [LW-1:0] prv_tab [NUM_BUFFERS];

  assign nx_rd = nxt_tab[nx_ra];
  assign pv_rd = prv_tab[pv_ra];

  // Reset chains all entries into the free list in index order
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        nxt_tab[i] <= LW'(i + 1);
        prv_tab[i] <= (i == 0) ? LW'(NUM_BUFFERS) : LW'(i - 1);
      end
    end else begin
      if (nx_we) begin
        nxt_tab[nx_wa] <= nx_wd;
      end
      if (pv_we) begin
        prv_tab[pv_wa] <= pv_wd;
      end
    end
  end

endmodule

// ===== sv/sample_dma_buffer_cache.sv =====
// Request: walks the used list comparing each entry; a miss then allocates a free entry and links it.
// Tick: walks the used list, moves each aged entry to the free list, then advances the frame count.
// A new request or tick is accepted only from idle, once the previous one has finished.
// Results are strobed for one cycle on done; the receiver cannot stall.
// Synchronous reset: all buffers free in index order, frame count zero.
// Top level of the sample DMA buffer cache.
module sample_dma_buffer_cache #(
  parameter int NUM_BUFFERS = sdbc_pkg::NUM_BUFFERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func,
  input  logic [sdbc_pkg::ADDR_W-1:0] req_addr,
  input  logic [sdbc_pkg::LEN_W-1:0]  req_len,
  input  logic                        buffer_bytes_we,
  input  logic [15:0]                 buffer_bytes_wdata,
  output logic                        done,
  output logic                        hit,
  output logic [sdbc_pkg::IDX_W-1:0]  buffer_index,
  output logic [15:0]                 byte_offset,
  output logic                        dma_start,
  output logic [sdbc_pkg::ADDR_W-1:0] dma_addr,
  output logic                        no_free_buffer
);

  localparam int IW = $clog2(NUM_BUFFERS);
  localparam int LW = $clog2(NUM_BUFFERS + 1);
  localparam int SW = $clog2(NUM_BUFFERS + 1);
  localparam logic [LW-1:0] NIL = LW'(NUM_BUFFERS);
  localparam int AW = sdbc_pkg::ADDR_W;
  localparam int TW = sdbc_pkg::TIME_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WCHK = 4'd1;
  localparam logic [3:0] S_WCMP = 4'd2;
  localparam logic [3:0] S_MSEL = 4'd3;
  localparam logic [3:0] S_MISS = 4'd4;
  localparam logic [3:0] S_PRE1 = 4'd5;
  localparam logic [3:0] S_PRE2 = 4'd6;
  localparam logic [3:0] S_SOLO = 4'd7;
  localparam logic [3:0] S_LA1  = 4'd8;
  localparam logic [3:0] S_LA2  = 4'd9;
  localparam logic [3:0] S_MOUT = 4'd10;
  localparam logic [3:0] S_TCHK = 4'd11;
  localparam logic [3:0] S_TCMP = 4'd12;
  localparam logic [3:0] S_TADV = 4'd13;

  logic [3:0]    state;
  logic [LW-1:0] e;
  logic [LW-1:0] last;
  logic [LW-1:0] la_to;
  logic [LW-1:0] la_n;
  logic [LW-1:0] tnext;
  logic [SW-1:0] steps;
  logic [LW-1:0] used_head;
  logic [LW-1:0] free_head;
  logic [TW-1:0] frame_count;
  logic [15:0]   buffer_bytes;
  logic          func_q;
  logic [AW-1:0] addr_q;
  logic [15:0]   len_q;

  logic [LW-1:0] nx_rd, pv_rd;
  logic [IW-1:0] nx_ra;
  logic          nx_we, pv_we;
  logic [IW-1:0] nx_wa, pv_wa;
  logic [LW-1:0] nx_wd, pv_wd;
  logic [AW-1:0] st_rdata;
  logic [TW-1:0] lu_rdata;
  logic          st_we, lu_we;

  function automatic logic is_nil(logic [LW-1:0] v);
    return v >= NIL;
  endfunction

  function automatic logic [IW-1:0] idx(logic [LW-1:0] v);
    return v[IW-1:0];
  endfunction

  assign busy = (state != S_IDLE);

  // Compare logic: request bounds and entry age
  logic [TW-1:0] addr_end, buf_end, aged_sum;
  logic          below_start, fits, aged, walk_end;
  assign addr_end    = {1'b0, addr_q} + {16'b0, len_q};
  assign buf_end     = {1'b0, st_rdata} + {16'b0, buffer_bytes};
  assign below_start = addr_q < st_rdata;
  assign fits        = buf_end >= addr_end;
  assign aged_sum    = lu_rdata + sdbc_pkg::AGE_LAG;
  assign aged        = aged_sum < frame_count;
  assign walk_end    = (steps == SW'(NUM_BUFFERS)) || is_nil(e);

  assign nx_ra = (state == S_LA1) ? idx(la_to) : idx(e);
  assign st_we = (state == S_MISS);
  assign lu_we = (state == S_MISS) || ((state == S_WCMP) && !below_start && fits);

  // Link table writes per sequencer step
  always_comb begin
    nx_we = 1'b0;
    nx_wa = idx(e);
    nx_wd = NIL;
    pv_we = 1'b0;
    pv_wa = idx(e);
    pv_wd = NIL;
    unique case (state)
      S_MISS: begin
        // unlink: prev[n] = p, next[p] = n
        pv_we = !is_nil(nx_rd);
        pv_wa = idx(nx_rd);
        pv_wd = pv_rd;
        nx_we = !is_nil(pv_rd);
        nx_wa = idx(pv_rd);
        nx_wd = nx_rd;
      end
      S_TCMP: begin
        pv_we = aged && !is_nil(nx_rd);
        pv_wa = idx(nx_rd);
        pv_wd = pv_rd;
        nx_we = aged && !is_nil(pv_rd);
        nx_wa = idx(pv_rd);
        nx_wd = nx_rd;
      end
      S_PRE1: begin
        nx_we = 1'b1;
        nx_wd = used_head;
        pv_we = 1'b1;
      end
      S_PRE2: begin
        pv_we = 1'b1;
        pv_wa = idx(la_n);
        pv_wd = e;
      end
      S_SOLO: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
      end
      S_LA1: begin
        nx_we = 1'b1;
        nx_wd = nx_rd;
        pv_we = 1'b1;
        pv_wd = la_to;
      end
      S_LA2: begin
        pv_we = !is_nil(la_n);
        pv_wa = idx(la_n);
        pv_wd = e;
        nx_we = 1'b1;
        nx_wa = idx(la_to);
        nx_wd = e;
      end
      default: begin
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes <= sdbc_pkg::BUFFER_BYTES_RST;
    end else if (buffer_bytes_we) begin
      buffer_bytes <= buffer_bytes_wdata;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      used_head   <= NIL;
      free_head   <= '0;
      frame_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            func_q <= func;
            addr_q <= req_addr;
            len_q  <= req_len;
            steps  <= '0;
            last   <= NIL;
            e      <= used_head;
            state  <= (func == sdbc_pkg::FUNC_TICK) ? S_TCHK : S_WCHK;
          end
        end
        S_WCHK: begin
          state <= walk_end ? S_MSEL : S_WCMP;
        end
        S_WCMP: begin
          if (below_start) begin
            state <= S_MSEL;
          end else if (fits) begin
            done           <= 1'b1;
            hit            <= 1'b1;
            buffer_index   <= sdbc_pkg::IDX_W'(e);
            byte_offset    <= 16'(addr_q - st_rdata);
            dma_start      <= 1'b0;
            dma_addr       <= '0;
            no_free_buffer <= 1'b0;
            state          <= S_IDLE;
          end else begin
            last  <= e;
            e     <= nx_rd;
            steps <= steps + 1'b1;
            state <= S_WCHK;
          end
        end
        S_MSEL: begin
          e <= free_head;
          if (is_nil(free_head)) begin
            done           <= 1'b1;
            hit            <= 1'b0;
            buffer_index   <= '0;
            byte_offset    <= '0;
            dma_start      <= 1'b0;
            dma_addr       <= '0;
            no_free_buffer <= 1'b1;
            state          <= S_IDLE;
          end else begin
            state <= S_MISS;
          end
        end
        S_MISS: begin
          free_head <= nx_rd;
          if (!is_nil(last)) begin
            la_to <= last;
            state <= S_LA1;
          end else if (!is_nil(used_head)) begin
            state <= S_PRE1;
          end else begin
            state <= S_SOLO;
          end
        end
        S_PRE1: begin
          la_n      <= used_head;
          used_head <= e;
          state     <= S_PRE2;
        end
        S_PRE2: begin
          state <= S_MOUT;
        end
        S_SOLO: begin
          if (func_q == sdbc_pkg::FUNC_TICK) begin
            state <= S_TADV;
          end else begin
            used_head <= e;
            state     <= S_MOUT;
          end
        end
        S_LA1: begin
          la_n  <= nx_rd;
          state <= S_LA2;
        end
        S_LA2: begin
          state <= (func_q == sdbc_pkg::FUNC_TICK) ? S_TADV : S_MOUT;
        end
        S_MOUT: begin
          done           <= 1'b1;
          hit            <= 1'b0;
          buffer_index   <= sdbc_pkg::IDX_W'(e);
          byte_offset    <= {15'b0, addr_q[0]};
          dma_start      <= 1'b1;
          dma_addr       <= {addr_q[AW-1:1], 1'b0};
          no_free_buffer <= 1'b0;
          state          <= S_IDLE;
        end
        S_TCHK: begin
          if (walk_end) begin
            frame_count    <= frame_count + 1'b1;
            done           <= 1'b1;
            hit            <= 1'b0;
            buffer_index   <= '0;
            byte_offset    <= '0;
            dma_start      <= 1'b0;
            dma_addr       <= '0;
            no_free_buffer <= 1'b0;
            state          <= S_IDLE;
          end else begin
            state <= S_TCMP;
          end
        end
        S_TCMP: begin
          tnext <= nx_rd;
          if (aged) begin
            if (e == used_head) begin
              used_head <= nx_rd;
            end
            if (!is_nil(free_head)) begin
              la_to <= free_head;
              state <= S_LA1;
            end else begin
              free_head <= e;
              state     <= S_SOLO;
            end
          end else begin
            state <= S_TADV;
          end
        end
        S_TADV: begin
          e     <= tnext;
          steps <= steps + 1'b1;
          state <= S_TCHK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  sdbc_links #(.NUM_BUFFERS(NUM_BUFFERS)) u_links (
    .clk   (clk),
    .rst   (rst),
    .nx_ra (nx_ra),
    .nx_rd (nx_rd),
    .pv_ra (idx(e)),
    .pv_rd (pv_rd),
    .nx_we (nx_we),
    .nx_wa (nx_wa),
    .nx_wd (nx_wd),
    .pv_we (pv_we),
    .pv_wa (pv_wa),
    .pv_wd (pv_wd)
  );

  // Entry start addresses
  sdbc_ram #(.WIDTH(AW), .DEPTH(NUM_BUFFERS)) u_start_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (idx(e)),
    .wdata ({addr_q[AW-1:1], 1'b0}),
    .raddr (idx(e)),
    .rdata (st_rdata)
  );

  // Entry last-use frames
  sdbc_ram #(.WIDTH(TW), .DEPTH(NUM_BUFFERS)) u_use_ram (
    .clk   (clk),
    .we    (lu_we),
    .waddr (idx(e)),
    .wdata (frame_count),
    .raddr (idx(e)),
    .rdata (lu_rdata)
  );

endmodule

// ===== sv/sdbc_checker.sv =====
// Port-level checker for the sample DMA buffer cache, bound to the top level.
module sdbc_props (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic                        dma_start,
  input logic [sdbc_pkg::ADDR_W-1:0] dma_addr,
  input logic                        no_free_buffer,
  input logic                        hit
);

  // A word is only delivered once the block is idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobed while busy");

  // An accepted word starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  // Finishing work always delivers a word
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("work ended without a result");

  // Outcomes exclude each other and the DMA address is even
  a_outcome: assert property (@(posedge clk) disable iff (rst)
    done |-> ($countones({hit, dma_start, no_free_buffer}) <= 1)
             && (!dma_start || !dma_addr[0]))
    else $error("bad result outcome");

endmodule

bind sample_dma_buffer_cache sdbc_props u_sdbc_props (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .dma_start      (dma_start),
  .dma_addr       (dma_addr),
  .no_free_buffer (no_free_buffer),
  .hit            (hit)
);
